// File: src/rotation_matrix_to_euler_top_macros.svh
// assertion helpers for the euler block
`ifndef ROTATION_MATRIX_TO_EULER_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_TOP_MACROS_SVH

`define RME_ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");

`define RME_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");

`endif

// File: src/rme_pkg.sv
`default_nettype none
package rme_pkg;
  localparam int STAGES = 16;
  localparam int AW = 36;
  localparam int SQ_STEPS = 16;
  localparam int LAT = 2 + SQ_STEPS + 1 + STAGES + 1;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sh06487ED51;

  typedef struct packed {
    logic signed [AW-1:0] x;
    logic signed [AW-1:0] y;
    logic signed [33:0]   ang;
    logic                 zero;
  } cord_t;

  typedef struct packed {
    logic signed [15:0] r00, r10, r20, r11, r12, r21, r22;
    logic [14:0]        thr;
  } item_t;

  function automatic logic signed [33:0] atan_tab(input int i);
    logic [31:0] t;
    begin
      unique case (i)
        0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
        3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
        6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
        9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
        12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
        15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
        18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
        21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
        default: t = 32'h0;
      endcase
      return $signed({2'b00, t});
    end
  endfunction

  function automatic cord_t pre_rot(input logic signed [17:0] y, input logic signed [17:0] x);
    cord_t c;
    logic signed [AW-1:0] xs, ys;
    begin
      xs = AW'(x) <<< 16;
      ys = AW'(y) <<< 16;
      c.zero = (x == 18'sd0) && (y == 18'sd0);
      c.ang = '0;
      c.x = xs;
      c.y = ys;
      if (x < 0) begin
        if (y >= 0) begin
          c.x = ys; c.y = -xs; c.ang = HALF_PI_Q30;
        end else begin
          c.x = -ys; c.y = xs; c.ang = -HALF_PI_Q30;
        end
      end
      return c;
    end
  endfunction

  function automatic cord_t cord_step(input cord_t c, input int i);
    cord_t n;
    begin
      n = c;
      if (c.y >= 0) begin
        n.x = c.x + (c.y >>> i); n.y = c.y - (c.x >>> i); n.ang = c.ang + atan_tab(i);
      end else begin
        n.x = c.x - (c.y >>> i); n.y = c.y + (c.x >>> i); n.ang = c.ang - atan_tab(i);
      end
      return n;
    end
  endfunction

  function automatic logic signed [15:0] finish(input cord_t c);
    logic signed [34:0] q;
    begin
      q = (35'(c.ang) + 35'sd65536) >>> 17;
      if (c.zero) return 16'sd0;
      if (q > 35'sd32767) return 16'sh7FFF;
      if (q < -35'sd32768) return 16'sh8000;
      return q[15:0];
    end
  endfunction
endpackage
`default_nettype wire

// File: src/rme_core.sv
`default_nettype none
// Pipeline: squares, sum, 16 root steps, select, 16 CORDIC stages x3, round.
module rme_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire rme_pkg::item_t   in_item,
  output logic                  out_valid,
  output logic [48:0]           out_data
);
  localparam int L = rme_pkg::LAT;
  logic [L-1:0] v;
  // stage 0: squares
  rme_pkg::item_t it0, it1;
  logic signed [31:0] p00, p10;
  logic [31:0] sq0, sq1;
  logic [32:0] sum1;
  assign p00 = in_item.r00 * in_item.r00;
  assign p10 = in_item.r10 * in_item.r10;
  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[L-2:0], in_valid};
    if (en) begin
      it0 <= in_item;
      sq0 <= $unsigned(p00);
      sq1 <= $unsigned(p10);
      it1 <= it0;
      sum1 <= {1'b0, sq0} + {1'b0, sq1};
    end
  end
  // restoring square root, one result bit per stage
  rme_pkg::item_t sit [rme_pkg::SQ_STEPS+1];
  logic [33:0] rem [rme_pkg::SQ_STEPS+1];
  logic [16:0] root [rme_pkg::SQ_STEPS+1];
  logic [32:0] rad [rme_pkg::SQ_STEPS+1];
  always_comb begin
    sit[0] = it1; rem[0] = '0; root[0] = '0; rad[0] = sum1;
  end
  for (genvar k = 0; k < rme_pkg::SQ_STEPS; k++) begin : g_sq
    logic [33:0] tr, tt;
    always_comb begin
      tr = {rem[k][31:0], rad[k][31-2*k -: 2]};
      tt = {15'd0, root[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sit[k+1] <= sit[k];
        rad[k+1] <= rad[k];
        if (tr >= tt) begin
          rem[k+1] <= tr - tt; root[k+1] <= {root[k][15:0], 1'b1};
        end else begin
          rem[k+1] <= tr; root[k+1] <= {root[k][15:0], 1'b0};
        end
      end
    end
  end
  // radicand is at most 2^31, so it fits in the low 32 bits
  logic [16:0] sy;
  assign sy = root[rme_pkg::SQ_STEPS];
  rme_pkg::cord_t cx [rme_pkg::STAGES+1], cy [rme_pkg::STAGES+1], cz [rme_pkg::STAGES+1];
  logic sg [rme_pkg::STAGES+1];
  always_ff @(posedge clk) begin
    if (en) begin
      logic s;
      rme_pkg::item_t t;
      t = sit[rme_pkg::SQ_STEPS];
      s = sy < {2'b00, t.thr};
      sg[0] <= s;
      cx[0] <= s ? rme_pkg::pre_rot(-18'(t.r12), 18'(t.r11))
                 : rme_pkg::pre_rot(18'(t.r21), 18'(t.r22));
      cz[0] <= s ? rme_pkg::pre_rot(18'sd0, 18'sd0)
                 : rme_pkg::pre_rot(18'(t.r10), 18'(t.r00));
      cy[0] <= rme_pkg::pre_rot(-18'(t.r20), $signed({1'b0, sy}));
    end
  end
  for (genvar k = 0; k < rme_pkg::STAGES; k++) begin : g_cd
    always_ff @(posedge clk) begin
      if (en) begin
        cx[k+1] <= rme_pkg::cord_step(cx[k], k);
        cy[k+1] <= rme_pkg::cord_step(cy[k], k);
        cz[k+1] <= rme_pkg::cord_step(cz[k], k);
        sg[k+1] <= sg[k];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) out_data <= {sg[rme_pkg::STAGES], rme_pkg::finish(cz[rme_pkg::STAGES]),
                         rme_pkg::finish(cy[rme_pkg::STAGES]),
                         rme_pkg::finish(cx[rme_pkg::STAGES])};
  end
  assign out_valid = v[L-1];
endmodule
`default_nettype wire

// File: src/rotation_matrix_to_euler_top.sv
`default_nettype none
// Rotation matrix (Q2.14) to XYZ Euler angles (Q3.13). One matrix per cycle
// while the output is not stalled. Stages: squares, sum, bit-per-stage square
// root, select, sixteen unrolled CORDIC stages, rounding. The whole pipeline
// advances when the output register is empty or being taken.
module rotation_matrix_to_euler_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // r00, r10, r20, r11, r12, r21, r22
  input  wire logic [111:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // angle_x, angle_y, angle_z
  output logic [47:0]       m_tdata,
  // singular
  output logic              m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [14:0] thr;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) thr <= 15'd1;
    else if (psel && penable && pwrite && paddr == 2'd0) thr <= pwdata[14:0];
  end
  assign prdata = (paddr == 2'd0) ? {17'd0, thr} : 32'd0;

  logic en, cv;
  logic [48:0] cd;
  rme_pkg::item_t it;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  always_comb begin
    it.r00 = s_tdata[15:0];  it.r10 = s_tdata[31:16]; it.r20 = s_tdata[47:32];
    it.r11 = s_tdata[63:48]; it.r12 = s_tdata[79:64]; it.r21 = s_tdata[95:80];
    it.r22 = s_tdata[111:96]; it.thr = thr;
  end
  rme_core u_core (.clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
                   .in_item(it), .out_valid(cv), .out_data(cd));
  // core output stage doubles as the output register
  assign m_tvalid = cv;
  assign m_tdata = cd[47:0];
  assign m_tuser = cd[48];
endmodule
`default_nettype wire

// File: src/rme_checker.sv
`default_nettype none
`include "rotation_matrix_to_euler_top_macros.svh"
module rme_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        pready
);
  `RME_ASSERT_CLK(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `RME_ASSERT_CLK(a_z0, clk, rst, m_tvalid && m_tuser |-> m_tdata[47:32] == 16'd0)
  `RME_ASSERT_CLK(a_rdy, clk, rst, s_tready == (!m_tvalid || m_tready))
  `RME_ASSERT_RST(a_pr, clk, pready)
endmodule
bind rotation_matrix_to_euler_top rme_checker u_chk (.clk(clk), .rst(rst),
  .s_tready(s_tready), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .pready(pready));
`default_nettype wire

// File: tb/rotation_matrix_to_euler_top_test.sv
`default_nettype none
module rotation_matrix_to_euler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTAGES = 16;
  localparam int LIMIT_CYCLES = 400000;
  localparam logic [1:0] ADDR_THRESHOLD = 2'd0;
  localparam int IDLE_NONE = 0, IDLE_SEND = 1, IDLE_RECV = 2, IDLE_BOTH = 3;

  typedef struct packed {
    logic signed [15:0] r22, r21, r12, r11, r20, r10, r00;
  } matrix_t;

  typedef struct packed {
    logic               singular;
    logic signed [15:0] az, ay, ax;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [111:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic m_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rotation_matrix_to_euler_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  logic [14:0] thr_model = 15'd1;
  matrix_t pending_mats[$];
  euler_t expected_angles[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_singular = 0;
  int idle_mode = IDLE_NONE;
  int unsigned cycle_count = 0;

  // vectoring CORDIC, result in Q3.13
  function automatic logic signed [15:0] cordic_angle(input longint yi, input longint xi);
    longint x, y, ang, t, xs, ys, q;
    longint atab[24];
    begin
      atab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
               64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
               64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
               64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
               64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
               64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
      if (xi == 0 && yi == 0) return 16'sd0;
      x = xi * 65536;
      y = yi * 65536;
      ang = 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; ang = 64'h6487ED51;
        end else begin
          t = x; x = -y; y = t; ang = -64'sh6487ED51;
        end
      end
      for (int i = 0; i < NSTAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; ang += atab[i];
        end else begin
          x -= ys; y += xs; ang -= atab[i];
        end
      end
      q = (ang + 65536) >>> 17;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    end
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint r;
    begin
      r = longint'($sqrt(real'(v)));
      while (r * r > v) r--;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    end
  endfunction

  function automatic euler_t predict_euler(input matrix_t m);
    euler_t e;
    longint sy;
    begin
      sy = floor_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
      e.singular = (sy < longint'(thr_model));
      if (!e.singular) begin
        e.ax = cordic_angle(m.r21, m.r22);
        e.az = cordic_angle(m.r10, m.r00);
      end else begin
        e.ax = cordic_angle(-longint'(m.r12), m.r11);
        e.az = 16'sd0;
      end
      e.ay = cordic_angle(-longint'(m.r20), sy);
      return e;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s at request %0d: got %0d, expected %0d", what, n_checked, got, want);
    n_errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_mats.size() != 0 &&
          !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) && $urandom_range(99) < 45)) begin
        matrix_t m;
        m = pending_mats.pop_front();
        expected_angles.push_back(predict_euler(m));
        s_tdata <= m;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        euler_t got, want;
        got = {m_tuser, m_tdata};
        if (expected_angles.size() == 0) begin
          $display("unexpected result at cycle %0d", cycle_count);
          n_errors++;
        end else begin
          want = expected_angles.pop_front();
          if (got.ax !== want.ax) report_mismatch("angle_x", got.ax, want.ax);
          if (got.ay !== want.ay) report_mismatch("angle_y", got.ay, want.ay);
          if (got.az !== want.az) report_mismatch("angle_z", got.az, want.az);
          if (got.singular !== want.singular)
            report_mismatch("singular", got.singular, want.singular);
          if (want.singular) n_singular++;
        end
        n_checked++;
      end
      m_tready <= !((idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) &&
                    $urandom_range(99) < 45);
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_threshold(input logic [14:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_THRESHOLD; pwdata <= {17'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    thr_model = value;
  endtask

  task automatic drain();
    while (pending_mats.size() != 0 || s_tvalid || expected_angles.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return $signed(16'($urandom_range(32767)) - 16'sd16384) >>> 1;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  // mostly near-orthonormal rows with random content, some noise
  function automatic matrix_t rand_matrix();
    matrix_t m;
    real a, b, c;
    begin
      m = {7{rand_field()}};
      for (int k = 0; k < 7; k++) m[k*16 +: 16] = rand_field();
      if ($urandom_range(2) != 0) begin
        a = ($urandom_range(6283) / 1000.0) - 3.1416;
        b = ($urandom_range(3141) / 1000.0) - 1.5708;
        c = ($urandom_range(6283) / 1000.0) - 3.1416;
        if ($urandom_range(7) == 0) b = ($urandom_range(1) ? 1.5708 : -1.5708);
        m.r00 = 16'($rtoi(16384.0 * $cos(b) * $cos(c)));
        m.r10 = 16'($rtoi(16384.0 * $cos(b) * $sin(c)));
        m.r20 = 16'($rtoi(-16384.0 * $sin(b)));
        m.r21 = 16'($rtoi(16384.0 * $cos(b) * $sin(a)));
        m.r22 = 16'($rtoi(16384.0 * $cos(b) * $cos(a)));
        m.r11 = 16'($rtoi(16384.0 * $cos(a)));
        m.r12 = 16'($rtoi(-16384.0 * $sin(a)));
      end
      return m;
    end
  endfunction

  initial begin
    matrix_t m;
    logic [14:0] thr_set[4];
    thr_set = '{15'd0, 15'd16384, 15'd32767, 15'd200};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero vectors, negative x with zero y, singular branch
    pending_mats.push_back('0);
    pending_mats.push_back({7{16'sh7FFF}});
    pending_mats.push_back({7{16'sh8000}});
    m = '0; m.r00 = 16'sh4000; m.r11 = 16'sh4000; m.r22 = 16'sh4000;
    pending_mats.push_back(m);
    m = '0; m.r00 = -16'sh4000; m.r22 = -16'sh4000; m.r11 = -16'sh4000;
    pending_mats.push_back(m);
    m = '0; m.r20 = -16'sh4000; m.r11 = 16'sh4000; m.r12 = 16'sh4000;
    pending_mats.push_back(m);
    m = '0; m.r20 = 16'sh4000; m.r11 = -16'sh4000;
    pending_mats.push_back(m);
    m = '0; m.r00 = 16'sh8000; m.r10 = 16'sh8000; m.r20 = 16'sh7FFF;
    pending_mats.push_back(m);
    m = '0; m.r10 = 16'sd1;
    pending_mats.push_back(m);
    for (int k = 0; k < 10; k++) pending_mats.push_back(rand_matrix());
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr_set[ph]);
      idle_mode = ph;
      for (int k = 0; k < 50; k++) pending_mats.push_back(rand_matrix());
      drain();
      // second burst in the same idle mode after a full drain
      for (int k = 0; k < 50; k++) pending_mats.push_back(rand_matrix());
      drain();
    end
    write_threshold(15'd1);
    idle_mode = IDLE_NONE;
    for (int k = 0; k < 20; k++) pending_mats.push_back(rand_matrix());
    drain();

    $display("checked %0d results (%0d singular) over thresholds 0, 1, 200, 16384, 32767",
             n_checked, n_singular);
    $display("with sender gaps, receiver stalls and both");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
